// ===== src/rdi_pkg.sv =====
// shared types, widths and codes for the ray-disc intersection pipeline
`default_nettype none

package rdi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned CRD_W  = 32;   // coordinate width
  localparam int unsigned CO_W   = 33;   // center minus origin
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned T_W    = 31;
  localparam int unsigned DEN_W  = 49;   // signed dot(normal, dir)
  localparam int unsigned NUM_W  = 50;   // signed dot(normal, center - origin)
  localparam int unsigned ADEN_W = 48;
  localparam int unsigned ANUM_W = 49;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [ADEN_W-1:0] PARALLEL_LIM = ADEN_W'(1) << 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;

  localparam logic [NRM_W-1:0] NORMAL_Z_RST = 16'd16384;
  localparam logic [T_W-1:0]   RADIUS_RST   = 31'd65536;

  // per-ray data that rides along with the divider
  typedef struct packed {
    logic signed [CO_W-1:0]  co_x;
    logic signed [CO_W-1:0]  co_y;
    logic signed [CO_W-1:0]  co_z;
    logic signed [CRD_W-1:0] d_x;
    logic signed [CRD_W-1:0] d_y;
    logic signed [CRD_W-1:0] d_z;
    logic                    pvalid;
    logic [T_W-1:0]          pt;
    logic                    ok;
  } side_t;

endpackage

`default_nettype wire

// ===== src/ray_disc_intersection.sv =====
// ray-disc intersection test, top level with configuration registers
//
// Input channel: in_valid_i / in_stall_o with one ray per transfer (origin,
// direction, prior hit record). Result channel: res_valid_o / res_stall_i
// with the updated closest-hit record, one result per ray, in order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i selecting
// center x,y,z (0..2), normal x,y,z (3..5) and radius (6); cfg_ready_o is
// always high. Write only while no ray is in flight.
// The pipeline has 3 plane stages (offsets, products, sums), 32 divider
// stages (entry plus one quotient bit per stage for 31-bit t) and 5 stages
// for offsets, squares and the radius compare. Throughput is one ray per
// cycle while the result channel is not stalled.
// Reset empties the pipeline and loads center 0, normal (0,0,1.0), radius
// 1.0. When the receiver stalls a valid result, the whole pipeline holds
// and in_stall_o rises; bubbles do not stall the input.
`default_nettype none

module ray_disc_intersection
  import rdi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire signed [CRD_W-1:0]   origin_x_i,
  input  wire signed [CRD_W-1:0]   origin_y_i,
  input  wire signed [CRD_W-1:0]   origin_z_i,
  input  wire signed [CRD_W-1:0]   dir_x_i,
  input  wire signed [CRD_W-1:0]   dir_y_i,
  input  wire signed [CRD_W-1:0]   dir_z_i,
  input  wire                      prior_valid_i,
  input  wire        [T_W-1:0]     prior_t_i,
  output logic                     res_valid_o,
  input  wire                      res_stall_i,
  output logic                     new_hit_o,
  output logic                     out_valid_o,
  output logic       [T_W-1:0]     out_t_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire        [CFG_IDX_W-1:0] cfg_index_i,
  input  wire        [CRD_W-1:0]   cfg_data_i
);

  logic signed [CRD_W-1:0] center_x_q, center_y_q, center_z_q;
  logic signed [NRM_W-1:0] normal_x_q, normal_y_q, normal_z_q;
  logic        [T_W-1:0]   radius_q;

  logic              en;
  logic              pl_valid, dv_valid;
  logic [ADEN_W-1:0] pl_aden;
  logic [ANUM_W-1:0] pl_anum;
  side_t             pl_side, dv_side;
  logic [T_W-1:0]    dv_t;

  assign cfg_ready_o = 1'b1;
  assign en          = !(res_valid_o && res_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      normal_x_q <= '0;
      normal_y_q <= '0;
      normal_z_q <= NORMAL_Z_RST;
      radius_q   <= RADIUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_CENTER_Z: center_z_q <= cfg_data_i;
        CFG_NORMAL_X: normal_x_q <= cfg_data_i[NRM_W-1:0];
        CFG_NORMAL_Y: normal_y_q <= cfg_data_i[NRM_W-1:0];
        CFG_NORMAL_Z: normal_z_q <= cfg_data_i[NRM_W-1:0];
        CFG_RADIUS:   radius_q   <= cfg_data_i[T_W-1:0];
        default: ;
      endcase
    end
  end

  rdi_plane u_plane (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .origin_z_i   (origin_z_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .prior_valid_i(prior_valid_i),
    .prior_t_i    (prior_t_i),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .center_z_i   (center_z_q),
    .normal_x_i   (normal_x_q),
    .normal_y_i   (normal_y_q),
    .normal_z_i   (normal_z_q),
    .valid_o      (pl_valid),
    .aden_o       (pl_aden),
    .anum_o       (pl_anum),
    .side_o       (pl_side)
  );

  rdi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pl_valid),
    .aden_i (pl_aden),
    .anum_i (pl_anum),
    .side_i (pl_side),
    .valid_o(dv_valid),
    .t_o    (dv_t),
    .side_o (dv_side)
  );

  rdi_disc #(.FRAC_BITS(FRAC_BITS)) u_disc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid),
    .t_i        (dv_t),
    .side_i     (dv_side),
    .radius_i   (radius_q),
    .valid_o    (res_valid_o),
    .new_hit_o  (new_hit_o),
    .out_valid_o(out_valid_o),
    .out_t_o    (out_t_o)
  );

  // a new hit always leaves a valid record
  a_hit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && new_hit_o |-> out_valid_o)
    else $error("new hit without valid record");

  // a hit lies strictly ahead of the origin
  a_hit_t_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && new_hit_o |-> out_t_o != '0)
    else $error("hit with zero distance");

  // nothing lies strictly inside a disc of zero radius
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && new_hit_o |-> radius_q != '0)
    else $error("hit on zero-radius disc");

endmodule

`default_nettype wire

// ===== src/rdi_plane.sv =====
// plane stages: center offsets, dot products, magnitudes and parallel test
`default_nettype none

module rdi_plane
  import rdi_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  wire signed [CRD_W-1:0]   origin_x_i,
  input  wire signed [CRD_W-1:0]   origin_y_i,
  input  wire signed [CRD_W-1:0]   origin_z_i,
  input  wire signed [CRD_W-1:0]   dir_x_i,
  input  wire signed [CRD_W-1:0]   dir_y_i,
  input  wire signed [CRD_W-1:0]   dir_z_i,
  input  wire                      prior_valid_i,
  input  wire        [T_W-1:0]     prior_t_i,
  input  wire signed [CRD_W-1:0]   center_x_i,
  input  wire signed [CRD_W-1:0]   center_y_i,
  input  wire signed [CRD_W-1:0]   center_z_i,
  input  wire signed [NRM_W-1:0]   normal_x_i,
  input  wire signed [NRM_W-1:0]   normal_y_i,
  input  wire signed [NRM_W-1:0]   normal_z_i,
  output logic                     valid_o,
  output logic       [ADEN_W-1:0]  aden_o,
  output logic       [ANUM_W-1:0]  anum_o,
  output side_t                    side_o
);

  logic  va_q, vb_q, vc_q;
  side_t sa_q, sb_q, sc_q;
  side_t sa_d, sc_d;
  logic signed [DEN_W-2:0] pd_x_q, pd_y_q, pd_z_q;
  logic signed [NUM_W-2:0] pn_x_q, pn_y_q, pn_z_q;
  logic signed [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] num;
  logic [ADEN_W-1:0] aden_d, aden_q;
  logic [ANUM_W-1:0] anum_d, anum_q;

  always_comb begin
    sa_d        = '0;
    sa_d.co_x   = CO_W'(center_x_i) - CO_W'(origin_x_i);
    sa_d.co_y   = CO_W'(center_y_i) - CO_W'(origin_y_i);
    sa_d.co_z   = CO_W'(center_z_i) - CO_W'(origin_z_i);
    sa_d.d_x    = dir_x_i;
    sa_d.d_y    = dir_y_i;
    sa_d.d_z    = dir_z_i;
    sa_d.pvalid = prior_valid_i;
    sa_d.pt     = prior_t_i;
  end

  assign den = DEN_W'(pd_x_q) + DEN_W'(pd_y_q) + DEN_W'(pd_z_q);
  assign num = NUM_W'(pn_x_q) + NUM_W'(pn_y_q) + NUM_W'(pn_z_q);
  assign aden_d = ADEN_W'(den[DEN_W-1] ? -den : den);
  assign anum_d = ANUM_W'(num[NUM_W-1] ? -num : num);

  always_comb begin
    sc_d    = sb_q;
    // hit only ahead of the origin and away from parallel
    sc_d.ok = (aden_d >= PARALLEL_LIM) && (num != '0)
              && (num[NUM_W-1] == den[DEN_W-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= sa_d;
      pd_x_q <= (DEN_W-1)'(normal_x_i) * (DEN_W-1)'(sa_q.d_x);
      pd_y_q <= (DEN_W-1)'(normal_y_i) * (DEN_W-1)'(sa_q.d_y);
      pd_z_q <= (DEN_W-1)'(normal_z_i) * (DEN_W-1)'(sa_q.d_z);
      pn_x_q <= (NUM_W-1)'(normal_x_i) * (NUM_W-1)'(sa_q.co_x);
      pn_y_q <= (NUM_W-1)'(normal_y_i) * (NUM_W-1)'(sa_q.co_y);
      pn_z_q <= (NUM_W-1)'(normal_z_i) * (NUM_W-1)'(sa_q.co_z);
      sb_q   <= sa_q;
      sc_q   <= sc_d;
      aden_q <= aden_d;
      anum_q <= anum_d;
    end
  end

  assign valid_o = vc_q;
  assign aden_o  = aden_q;
  assign anum_o  = anum_q;
  assign side_o  = sc_q;

endmodule

`default_nettype wire

// ===== src/rdi_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating t
`default_nettype none

module rdi_div
  import rdi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                en_i,
  input  wire                valid_i,
  input  wire  [ADEN_W-1:0]  aden_i,
  input  wire  [ANUM_W-1:0]  anum_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [T_W-1:0]     t_o,
  output side_t              side_o
);

  localparam int unsigned OV_W = ADEN_W + T_W - FRAC_BITS;

  logic              vld_q  [T_W+1];
  logic [ADEN_W-1:0] rem_q  [T_W+1];
  logic [ADEN_W-1:0] den_q  [T_W+1];
  logic [T_W-1:0]    nb_q   [T_W+1];
  logic [T_W-1:0]    quo_q  [T_W+1];
  logic              ovf_q  [T_W+1];
  side_t             side_q [T_W+1];

  // entry stage: overflow check and the leading partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ADEN_W'(anum_i >> (T_W - FRAC_BITS));
      nb_q[0]   <= T_W'(anum_i << FRAC_BITS);
      den_q[0]  <= aden_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= (OV_W'(aden_i) << (T_W - FRAC_BITS)) <= OV_W'(anum_i);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < T_W; k++) begin : g_step
    logic [ADEN_W:0] x;
    logic            ge;

    assign x  = {rem_q[k], nb_q[k][T_W-1]};
    assign ge = x >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? ADEN_W'(x - {1'b0, den_q[k]}) : ADEN_W'(x);
        nb_q[k+1]   <= nb_q[k] << 1;
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= {quo_q[k][T_W-2:0], ge};
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[T_W];
  assign t_o     = ovf_q[T_W] ? '1 : quo_q[T_W];
  assign side_o  = side_q[T_W];

endmodule

`default_nettype wire

// ===== src/rdi_disc.sv =====
// hit point offsets, radius test and closest-hit record update
`default_nettype none

module rdi_disc
  import rdi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  wire  [T_W-1:0]    t_i,
  input  side_t             side_i,
  input  wire  [T_W-1:0]    radius_i,
  output logic              valid_o,
  output logic              new_hit_o,
  output logic              out_valid_o,
  output logic [T_W-1:0]    out_t_o
);

  localparam int unsigned PM_W = CRD_W + T_W;
  localparam int unsigned V_W  = 64;
  localparam int unsigned SQ_W = 2 * T_W;
  localparam int unsigned S_W  = SQ_W + 2;

  logic           v0_q, v1_q, v2_q, v3_q, v4_q;
  side_t          s0_q, s1_q, s2_q, s3_q;
  side_t          s0_d;
  logic [T_W-1:0] t0_q, t1_q, t2_q, t3_q;
  logic           ok0_d;

  logic [CRD_W-1:0] dm_x, dm_y, dm_z;
  logic [PM_W-1:0]  pm_x_q, pm_y_q, pm_z_q;

  logic signed [V_W-1:0] v_x, v_y, v_z;
  logic [V_W-1:0]        a_x, a_y, a_z;
  logic [T_W-1:0]        a_x_q, a_y_q, a_z_q;
  logic                  far2_q, far3_q;

  logic [SQ_W-1:0] sq_x_q, sq_y_q, sq_z_q, rsq_q;
  logic [S_W-1:0]  ssum;
  logic            hit;

  logic           new_hit_q, out_valid_q;
  logic [T_W-1:0] out_t_q;

  assign ok0_d = side_i.ok && (t_i != '0) && !(side_i.pvalid && (t_i > side_i.pt));

  always_comb begin
    s0_d    = side_i;
    s0_d.ok = ok0_d;
  end

  function automatic logic [CRD_W-1:0] mag32(input logic [CRD_W-1:0] d);
    return d[CRD_W-1] ? (~d + CRD_W'(1)) : d;
  endfunction

  function automatic logic signed [V_W-1:0] offs(input logic [PM_W-1:0] pm,
                                                  input logic dneg,
                                                  input logic signed [CO_W-1:0] co);
    logic signed [V_W-1:0] p;
    p = V_W'(pm >> FRAC_BITS);
    if (dneg) p = -p;
    return p - V_W'(co);
  endfunction

  assign dm_x = mag32(s0_q.d_x);
  assign dm_y = mag32(s0_q.d_y);
  assign dm_z = mag32(s0_q.d_z);

  assign v_x = offs(pm_x_q, s1_q.d_x[CRD_W-1], s1_q.co_x);
  assign v_y = offs(pm_y_q, s1_q.d_y[CRD_W-1], s1_q.co_y);
  assign v_z = offs(pm_z_q, s1_q.d_z[CRD_W-1], s1_q.co_z);
  assign a_x = v_x[V_W-1] ? V_W'(-v_x) : V_W'(v_x);
  assign a_y = v_y[V_W-1] ? V_W'(-v_y) : V_W'(v_y);
  assign a_z = v_z[V_W-1] ? V_W'(-v_z) : V_W'(v_z);

  assign ssum = S_W'(sq_x_q) + S_W'(sq_y_q) + S_W'(sq_z_q);
  assign hit  = s3_q.ok && !far3_q && (ssum < S_W'(rsq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q    <= s0_d;
      t0_q    <= t_i;
      pm_x_q  <= PM_W'(dm_x) * PM_W'(t0_q);
      pm_y_q  <= PM_W'(dm_y) * PM_W'(t0_q);
      pm_z_q  <= PM_W'(dm_z) * PM_W'(t0_q);
      s1_q    <= s0_q;
      t1_q    <= t0_q;
      // any offset of 2^31 or more lies outside every radius
      a_x_q   <= a_x[T_W-1:0];
      a_y_q   <= a_y[T_W-1:0];
      a_z_q   <= a_z[T_W-1:0];
      far2_q  <= (a_x[V_W-1:T_W] != '0) || (a_y[V_W-1:T_W] != '0)
                 || (a_z[V_W-1:T_W] != '0);
      s2_q    <= s1_q;
      t2_q    <= t1_q;
      sq_x_q  <= SQ_W'(a_x_q) * SQ_W'(a_x_q);
      sq_y_q  <= SQ_W'(a_y_q) * SQ_W'(a_y_q);
      sq_z_q  <= SQ_W'(a_z_q) * SQ_W'(a_z_q);
      rsq_q   <= SQ_W'(radius_i) * SQ_W'(radius_i);
      far3_q  <= far2_q;
      s3_q    <= s2_q;
      t3_q    <= t2_q;
      new_hit_q   <= hit;
      out_valid_q <= s3_q.pvalid | hit;
      out_t_q     <= hit ? t3_q : s3_q.pt;
    end
  end

  assign valid_o     = v4_q;
  assign new_hit_o   = new_hit_q;
  assign out_valid_o = out_valid_q;
  assign out_t_o     = out_t_q;

endmodule

`default_nettype wire
